[src/amgs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared types and defaults for the adjacency matrix graph store: opcodes,
// status codes, address modes and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package amgs_pkg;

  // defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int NO_EDGE_DEF      = 65535;

  // field widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int LABEL_W  = 8;
  localparam int IN_WT_W  = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_V  = 3'd0,
    OP_INS_E  = 3'd1,
    OP_DEL_V  = 3'd2,
    OP_DEL_E  = 3'd3,
    OP_HAS_V  = 3'd4,
    OP_HAS_E  = 3'd5,
    OP_LOCATE = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUP       = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_EDGE   = 3'd4
  } status_t;

  // label memory address modes
  typedef enum logic [1:0] {
    LM_J   = 2'd0,  // scan slot j
    LM_I1  = 2'd1,  // slot i+1 (shift source)
    LM_I   = 2'd2,  // slot i (shift destination)
    LM_CNT = 2'd3   // append slot
  } lbl_mode_t;

  // matrix address modes (row, column)
  typedef enum logic [2:0] {
    MM_AB      = 3'd0,  // (la, lb)
    MM_BA      = 3'd1,  // (lb, la)
    MM_CNT_I   = 3'd2,  // (count, i)
    MM_I_CNT   = 3'd3,  // (i, count)
    MM_ROW_SRC = 3'd4,  // (i+1, j)
    MM_ROW_DST = 3'd5,  // (i, j)
    MM_COL_SRC = 3'd6,  // (j, i+1)
    MM_COL_DST = 3'd7   // (j, i)
  } mat_mode_t;

  typedef enum logic [1:0] {
    WD_WEIGHT = 2'd0,
    WD_NONE   = 2'd1,
    WD_READ   = 2'd2
  } wdata_sel_t;

  typedef enum logic [1:0] {
    IX_ZERO = 2'd0,
    IX_LA   = 2'd1,
    IX_I    = 2'd2
  } idx_sel_t;

  typedef struct packed {
    logic       latch;      // capture request, clear match flags
    logic       cmp_en;     // compare label read data against a and b
    logic       lbl_rd;
    logic       lbl_wr;
    lbl_mode_t  lbl_mode;
    logic       mat_rd;
    logic       mat_wr;
    mat_mode_t  mat_mode;
    wdata_sel_t wd_sel;
    logic       i_clr;
    logic       i_load;     // i <= la
    logic       i_inc;
    logic       j_clr;
    logic       j_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_set;
    status_t    res_status;
    logic       res_ans;
    idx_sel_t   res_idx;
  } amgs_cmd_t;

  typedef struct packed {
    op_t  op;
    logic fa;
    logic fb;
    logic full;
    logic j_eq_cnt;
    logic j1_eq_cnt;
    logic i1_ge_cnt;
    logic i_eq_cnt;
    logic cell_none;
  } amgs_stat_t;

endpackage
`default_nettype wire

[src/adjacency_matrix_graph_store_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_top
// Undirected weighted graph store: label list plus symmetric weight matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (in_op, in_vertex_a, in_vertex_b, in_weight) is taken on
//   a rising edge with start high and busy low. busy stays high until the
//   result is shown. Each request gives one result beat: out_status,
//   out_answer, out_vertex_index and out_vertex_total are valid for the one
// cycle that out_strobe is high. The receiver cannot stall; the fields
// then hold until the next request sets its result.
// Sequence of a request:
//   every request first scans the label memory, one slot per
//   label-memory read and compare. After that:
//   has vertex, locate, nop, lookup and insert failures: result directly;
//   insert edge: two matrix writes; has edge and a missing-edge delete:
//   one matrix read; delete edge: one read, then two writes;
//   insert vertex: two matrix writes per row/column slot;
//   delete vertex: label, row and column moves, one matrix-port read
//   and write per cell moved. busy drops the cycle after the result beat.
// Reset clears the vertex count and the controller; memory contents are
// not cleared, since no cell is read before it is written.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_top import amgs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter int NO_EDGE      = NO_EDGE_DEF,
  localparam int IW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [LABEL_W-1:0]  in_vertex_a,
  input  wire logic [LABEL_W-1:0]  in_vertex_b,
  input  wire logic [IN_WT_W-1:0]  in_weight,
  output logic                     out_strobe,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_answer,
  output logic [IW-1:0]            out_vertex_index,
  output logic [CW-1:0]            out_vertex_total
);

  amgs_cmd_t  cmd;
  amgs_stat_t stat;

  // controller
  amgs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // datapath
  amgs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .NO_EDGE      (NO_EDGE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_weight        (in_weight),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_answer       (out_answer),
    .out_vertex_index (out_vertex_index),
    .out_vertex_total (out_vertex_total)
  );

endmodule
`default_nettype wire

[src/amgs_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amgs_dp
// Datapath: label memory, weight matrix memory, loop counters, match flags,
// vertex count and result registers. Driven by commands from amgs_ctrl.
// ----------------------------------------------------------------------------
module amgs_dp import amgs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter int NO_EDGE      = NO_EDGE_DEF,
  localparam int IW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1),
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [LABEL_W-1:0]  in_vertex_a,
  input  wire logic [LABEL_W-1:0]  in_vertex_b,
  input  wire logic [IN_WT_W-1:0]  in_weight,
  input  wire amgs_cmd_t           cmd,
  output amgs_stat_t               stat,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_answer,
  output logic [IW-1:0]            out_vertex_index,
  output logic [CW-1:0]            out_vertex_total
);

  localparam logic [WEIGHT_BITS-1:0] NONE_W = WEIGHT_BITS'(NO_EDGE);

  // memories
  logic [LABEL_W-1:0]     lbl_mem [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] mat_mem [MAX_VERTICES * MAX_VERTICES];
  logic [LABEL_W-1:0]     lbl_q_r;
  logic [WEIGHT_BITS-1:0] mat_q_r;

  // request and working registers
  op_t                    op_r;
  logic [LABEL_W-1:0]     a_r, b_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic                   fa_r, fb_r;
  logic [IW-1:0]          la_r, lb_r;
  logic [CW-1:0]          i_r, j_r, cnt_r;
  status_t                status_r;
  logic                   ans_r;
  logic [IW-1:0]          idx_r;

  logic [CW-1:0]          i1, j1;
  logic [IW-1:0]          row, col, lbl_addr;
  logic [AW-1:0]          mat_addr;
  logic [WEIGHT_BITS-1:0] mat_wdata;
  logic [LABEL_W-1:0]     lbl_wdata;

  assign i1 = i_r + CW'(1);
  assign j1 = j_r + CW'(1);

  // label address select
  always_comb begin
    unique case (cmd.lbl_mode)
      LM_J:    lbl_addr = j_r[IW-1:0];
      LM_I1:   lbl_addr = i1[IW-1:0];
      LM_I:    lbl_addr = i_r[IW-1:0];
      LM_CNT:  lbl_addr = cnt_r[IW-1:0];
      default: lbl_addr = j_r[IW-1:0];
    endcase
  end

  assign lbl_wdata = (cmd.lbl_mode == LM_CNT) ? a_r : lbl_q_r;

  // matrix cell select
  always_comb begin
    unique case (cmd.mat_mode)
      MM_AB:      begin row = la_r;           col = lb_r;           end
      MM_BA:      begin row = lb_r;           col = la_r;           end
      MM_CNT_I:   begin row = cnt_r[IW-1:0];  col = i_r[IW-1:0];    end
      MM_I_CNT:   begin row = i_r[IW-1:0];    col = cnt_r[IW-1:0];  end
      MM_ROW_SRC: begin row = i1[IW-1:0];     col = j_r[IW-1:0];    end
      MM_ROW_DST: begin row = i_r[IW-1:0];    col = j_r[IW-1:0];    end
      MM_COL_SRC: begin row = j_r[IW-1:0];    col = i1[IW-1:0];     end
      MM_COL_DST: begin row = j_r[IW-1:0];    col = i_r[IW-1:0];    end
      default:    begin row = la_r;           col = lb_r;           end
    endcase
  end

  assign mat_addr = AW'(row) * AW'(MAX_VERTICES) + AW'(col);

  always_comb begin
    unique case (cmd.wd_sel)
      WD_WEIGHT: mat_wdata = w_r;
      WD_NONE:   mat_wdata = NONE_W;
      WD_READ:   mat_wdata = mat_q_r;
      default:   mat_wdata = NONE_W;
    endcase
  end

  // label memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.lbl_wr) begin
      lbl_mem[lbl_addr] <= lbl_wdata;
    end
    if (cmd.lbl_rd) begin
      lbl_q_r <= lbl_mem[lbl_addr];
    end
  end

  // matrix memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mat_wr) begin
      mat_mem[mat_addr] <= mat_wdata;
    end
    if (cmd.mat_rd) begin
      mat_q_r <= mat_mem[mat_addr];
    end
  end

  // request capture and label search
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= op_t'(in_op);
      a_r  <= in_vertex_a;
      b_r  <= in_vertex_b;
      w_r  <= WEIGHT_BITS'(in_weight);
      fa_r <= 1'b0;
      fb_r <= 1'b0;
      la_r <= '0;
      lb_r <= '0;
    end else if (cmd.cmp_en) begin
      // first match wins
      if (!fa_r && lbl_q_r == a_r) begin
        fa_r <= 1'b1;
        la_r <= j_r[IW-1:0];
      end
      if (!fb_r && lbl_q_r == b_r) begin
        fb_r <= 1'b1;
        lb_r <= j_r[IW-1:0];
      end
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_load) begin
      i_r <= CW'(la_r);
    end else if (cmd.i_inc) begin
      i_r <= i1;
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j1;
    end
  end

  // vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      status_r <= cmd.res_status;
      ans_r    <= cmd.res_ans;
      unique case (cmd.res_idx)
        IX_ZERO: idx_r <= '0;
        IX_LA:   idx_r <= la_r;
        IX_I:    idx_r <= i_r[IW-1:0];
        default: idx_r <= '0;
      endcase
    end
  end

  // status to controller
  assign stat.op        = op_r;
  assign stat.fa        = fa_r;
  assign stat.fb        = fb_r;
  assign stat.full      = (cnt_r == CW'(MAX_VERTICES));
  assign stat.j_eq_cnt  = (j_r == cnt_r);
  assign stat.j1_eq_cnt = (j1 == cnt_r);
  assign stat.i1_ge_cnt = (i1 >= cnt_r);
  assign stat.i_eq_cnt  = (i_r == cnt_r);
  assign stat.cell_none = (mat_q_r == NONE_W);

  assign out_status       = status_r;
  assign out_answer       = ans_r;
  assign out_vertex_index = idx_r;
  assign out_vertex_total = cnt_r;

endmodule
`default_nettype wire

[src/amgs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// amgs_ctrl
// Controller: sequences the label search, the op dispatch, edge accesses,
// the write loop of vertex insert and the memory move loops of vertex delete.
// ----------------------------------------------------------------------------
module amgs_ctrl import amgs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire amgs_stat_t stat,
  output amgs_cmd_t       cmd,
  output logic            busy,
  output logic            out_strobe
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_CHK, S_SCAN_CMP, S_DISPATCH,
    S_INS_W1, S_INS_W2,
    S_EDGE_W1, S_EDGE_W2,
    S_DEL_RD, S_DEL_CHK, S_DEL_W1, S_DEL_W2,
    S_HAS_RD, S_HAS_CHK,
    S_LBL_CHK, S_LBL_RD, S_LBL_WR,
    S_ROW_CHK_I, S_ROW_CHK_J, S_ROW_RD, S_ROW_WR,
    S_COL_CHK_I, S_COL_CHK_J, S_COL_RD, S_COL_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;

  // result helper
  function automatic amgs_cmd_t set_res(amgs_cmd_t c, status_t s, logic ans, idx_sel_t ix);
    amgs_cmd_t r;
    r            = c;
    r.res_set    = 1'b1;
    r.res_status = s;
    r.res_ans    = ans;
    r.res_idx    = ix;
    return r;
  endfunction

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          cmd.j_clr = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      // label search, one slot per S_SCAN_CHK/S_SCAN_CMP pass
      S_SCAN_CHK: begin
        if (stat.j_eq_cnt) begin
          state_nxt = S_DISPATCH;
        end else begin
          cmd.lbl_rd   = 1'b1;
          cmd.lbl_mode = LM_J;
          state_nxt    = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.cmp_en = 1'b1;
        cmd.j_inc  = 1'b1;
        state_nxt  = S_SCAN_CHK;
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        unique case (stat.op)
          OP_INS_V: begin
            if (stat.fa) begin
              cmd = set_res(cmd, ST_DUP, 1'b0, IX_LA);
            end else if (stat.full) begin
              cmd = set_res(cmd, ST_FULL, 1'b0, IX_ZERO);
            end else begin
              cmd.lbl_wr   = 1'b1;
              cmd.lbl_mode = LM_CNT;
              cmd.i_clr    = 1'b1;
              state_nxt    = S_INS_W1;
            end
          end
          OP_INS_E: begin
            if (!stat.fa || !stat.fb) begin
              cmd = set_res(cmd, ST_NOT_FOUND, 1'b0, IX_ZERO);
            end else begin
              state_nxt = S_EDGE_W1;
            end
          end
          OP_DEL_V: begin
            if (!stat.fa) begin
              cmd = set_res(cmd, ST_NOT_FOUND, 1'b0, IX_ZERO);
            end else begin
              cmd.i_load = 1'b1;
              state_nxt  = S_LBL_CHK;
            end
          end
          OP_DEL_E: begin
            if (!stat.fa || !stat.fb) begin
              cmd = set_res(cmd, ST_NOT_FOUND, 1'b0, IX_ZERO);
            end else begin
              state_nxt = S_DEL_RD;
            end
          end
          OP_HAS_V: begin
            cmd = set_res(cmd, ST_OK, stat.fa, IX_ZERO);
          end
          OP_HAS_E: begin
            if (!stat.fa || !stat.fb) begin
              cmd = set_res(cmd, ST_OK, 1'b0, IX_ZERO);
            end else begin
              state_nxt = S_HAS_RD;
            end
          end
          OP_LOCATE: begin
            if (stat.fa) begin
              cmd = set_res(cmd, ST_OK, 1'b1, IX_LA);
            end else begin
              cmd = set_res(cmd, ST_NOT_FOUND, 1'b0, IX_ZERO);
            end
          end
          OP_NOP: begin
            cmd = set_res(cmd, ST_OK, 1'b0, IX_ZERO);
          end
          default: begin
            cmd = set_res(cmd, ST_OK, 1'b0, IX_ZERO);
          end
        endcase
      end
      // new vertex row and column to no-edge
      S_INS_W1: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_CNT_I;
        cmd.wd_sel   = WD_NONE;
        state_nxt    = S_INS_W2;
      end
      S_INS_W2: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_I_CNT;
        cmd.wd_sel   = WD_NONE;
        if (stat.i_eq_cnt) begin
          cmd         = set_res(cmd, ST_OK, 1'b0, IX_I);
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_INS_W1;
        end
      end
      // insert edge, both directions
      S_EDGE_W1: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_AB;
        cmd.wd_sel   = WD_WEIGHT;
        state_nxt    = S_EDGE_W2;
      end
      S_EDGE_W2: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_BA;
        cmd.wd_sel   = WD_WEIGHT;
        cmd          = set_res(cmd, ST_OK, 1'b0, IX_ZERO);
        state_nxt    = S_DONE;
      end
      // delete edge
      S_DEL_RD: begin
        cmd.mat_rd   = 1'b1;
        cmd.mat_mode = MM_AB;
        state_nxt    = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (stat.cell_none) begin
          cmd       = set_res(cmd, ST_NO_EDGE, 1'b0, IX_ZERO);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DEL_W1;
        end
      end
      S_DEL_W1: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_AB;
        cmd.wd_sel   = WD_NONE;
        state_nxt    = S_DEL_W2;
      end
      S_DEL_W2: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_BA;
        cmd.wd_sel   = WD_NONE;
        cmd          = set_res(cmd, ST_OK, 1'b0, IX_ZERO);
        state_nxt    = S_DONE;
      end
      // has edge
      S_HAS_RD: begin
        cmd.mat_rd   = 1'b1;
        cmd.mat_mode = MM_AB;
        state_nxt    = S_HAS_CHK;
      end
      S_HAS_CHK: begin
        cmd       = set_res(cmd, ST_OK, !stat.cell_none, IX_ZERO);
        state_nxt = S_DONE;
      end
      // delete vertex: close gap in label list
      S_LBL_CHK: begin
        if (stat.i1_ge_cnt) begin
          cmd.i_load = 1'b1;
          cmd.j_clr  = 1'b1;
          state_nxt  = S_ROW_CHK_I;
        end else begin
          cmd.lbl_rd   = 1'b1;
          cmd.lbl_mode = LM_I1;
          state_nxt    = S_LBL_RD;
        end
      end
      S_LBL_RD: begin
        state_nxt = S_LBL_WR;
        cmd.lbl_wr   = 1'b1;
        cmd.lbl_mode = LM_I;
        cmd.i_inc    = 1'b1;
        state_nxt    = S_LBL_CHK;
      end
      S_LBL_WR: begin
        state_nxt = S_LBL_CHK;
      end
      // shift rows up
      S_ROW_CHK_I: begin
        if (stat.i1_ge_cnt) begin
          cmd.i_load = 1'b1;
          cmd.j_clr  = 1'b1;
          state_nxt  = S_COL_CHK_I;
        end else begin
          cmd.j_clr = 1'b1;
          state_nxt = S_ROW_CHK_J;
        end
      end
      S_ROW_CHK_J: begin
        if (stat.j_eq_cnt) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_ROW_CHK_I;
        end else begin
          cmd.mat_rd   = 1'b1;
          cmd.mat_mode = MM_ROW_SRC;
          state_nxt    = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_ROW_DST;
        cmd.wd_sel   = WD_READ;
        cmd.j_inc    = 1'b1;
        state_nxt    = S_ROW_CHK_J;
      end
      S_ROW_WR: begin
        state_nxt = S_ROW_CHK_J;
      end
      // shift columns left
      S_COL_CHK_I: begin
        if (stat.i1_ge_cnt) begin
          cmd         = set_res(cmd, ST_OK, 1'b0, IX_ZERO);
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.j_clr = 1'b1;
          state_nxt = S_COL_CHK_J;
        end
      end
      S_COL_CHK_J: begin
        if (stat.j1_eq_cnt) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_COL_CHK_I;
        end else begin
          cmd.mat_rd   = 1'b1;
          cmd.mat_mode = MM_COL_SRC;
          state_nxt    = S_COL_RD;
        end
      end
      S_COL_RD: begin
        cmd.mat_wr   = 1'b1;
        cmd.mat_mode = MM_COL_DST;
        cmd.wd_sel   = WD_READ;
        cmd.j_inc    = 1'b1;
        state_nxt    = S_COL_CHK_J;
      end
      S_COL_WR: begin
        state_nxt = S_COL_CHK_J;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_nxt == S_DONE);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the adjacency matrix graph store against a behavioral graph model.
// A short table of directed requests is followed by random requests that
// grow and shrink the graph, with burst/gap pacing on the request side.
// Each result beat is checked field by field against the table or model.
// ----------------------------------------------------------------------------
module testbench;
  import amgs_pkg::*;

  localparam int NV        = 16;
  localparam int N_RANDOM  = 1500;
  localparam int IDLE_MAX  = 20000;
  localparam logic [15:0] NONE_W = 16'hFFFF;

  typedef struct packed {
    status_t    status;
    logic       answer;
    logic [3:0] index;
    logic [4:0] total;
  } graph_result_t;

  typedef struct {
    op_t           op;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [15:0]   w;
    bit            typed;
    graph_result_t res;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_op       = '0;
  logic [7:0]  in_vertex_a = '0;
  logic [7:0]  in_vertex_b = '0;
  logic [15:0] in_weight   = '0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic        out_answer;
  logic [3:0]  out_vertex_index;
  logic [4:0]  out_vertex_total;

  adjacency_matrix_graph_store_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_weight(in_weight), .out_strobe(out_strobe), .out_status(out_status),
    .out_answer(out_answer), .out_vertex_index(out_vertex_index),
    .out_vertex_total(out_vertex_total)
  );

  initial forever #1 clk = ~clk;

  // shadow graph state
  logic [7:0]  g_labels [NV];
  logic [15:0] g_weights [NV][NV];
  int          g_count;

  dir_row_t      dir_tab [$];
  graph_result_t pending_results [$];
  graph_result_t next_res;
  int  n_items, item_idx, err_count, idle_cycles;
  int  burst_left, gap_left;
  bit  rst_done;

  // ---- graph predictor ----
  function automatic bit find_label(logic [7:0] lbl, output int slot);
    slot = 0;
    for (int i = 0; i < g_count; i++)
      if (g_labels[i] == lbl) begin
        slot = i;
        return 1;
      end
    return 0;
  endfunction

  function automatic graph_result_t graph_apply(op_t op, logic [7:0] a,
                                                logic [7:0] b, logic [15:0] w);
    graph_result_t r;
    int  sa, sb, n;
    bit  fa, fb;
    r = '{status: ST_OK, answer: 1'b0, index: '0, total: '0};
    fa = find_label(a, sa);
    fb = find_label(b, sb);
    case (op)
      OP_INS_V: begin
        if (fa) begin
          r.status = ST_DUP;
          r.index  = 4'(sa);
        end else if (g_count >= NV) begin
          r.status = ST_FULL;
        end else begin
          g_labels[g_count] = a;
          for (int i = 0; i <= g_count; i++) begin
            g_weights[g_count][i] = NONE_W;
            g_weights[i][g_count] = NONE_W;
          end
          r.index = 4'(g_count);
          g_count++;
        end
      end
      OP_INS_E: begin
        if (!fa || !fb) r.status = ST_NOT_FOUND;
        else begin
          g_weights[sa][sb] = w;
          g_weights[sb][sa] = w;
        end
      end
      OP_DEL_V: begin
        if (!fa) r.status = ST_NOT_FOUND;
        else begin
          n = g_count;
          // close the gap in labels, then rows, then columns
          for (int i = sa; i + 1 < n; i++) g_labels[i] = g_labels[i+1];
          for (int i = sa; i + 1 < n; i++)
            for (int j = 0; j < n; j++) g_weights[i][j] = g_weights[i+1][j];
          for (int i = sa; i + 1 < n; i++)
            for (int j = 0; j + 1 < n; j++) g_weights[j][i] = g_weights[j][i+1];
          g_count = n - 1;
        end
      end
      OP_DEL_E: begin
        if (!fa || !fb) r.status = ST_NOT_FOUND;
        else if (g_weights[sa][sb] == NONE_W) r.status = ST_NO_EDGE;
        else begin
          g_weights[sa][sb] = NONE_W;
          g_weights[sb][sa] = NONE_W;
        end
      end
      OP_HAS_V: r.answer = fa;
      OP_HAS_E: r.answer = fa && fb && (g_weights[sa][sb] != NONE_W);
      OP_LOCATE: begin
        if (fa) begin
          r.answer = 1'b1;
          r.index  = 4'(sa);
        end else r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.total = 5'(g_count);
    return r;
  endfunction

  // ---- stimulus ----
  task automatic add_row(op_t op, logic [7:0] a, logic [7:0] b, logic [15:0] w,
                         bit typed = 0, status_t st = ST_OK, logic ans = 0,
                         int idx = 0, int tot = 0);
    dir_row_t row;
    row.op = op; row.a = a; row.b = b; row.w = w; row.typed = typed;
    row.res = '{status: st, answer: ans, index: 4'(idx), total: 5'(tot)};
    dir_tab.push_back(row);
  endtask

  // mostly labels already in the graph, some fresh ones
  function automatic logic [7:0] pick_label();
    if (g_count > 0 && $urandom_range(0, 3) != 0)
      return g_labels[$urandom_range(0, g_count - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic op_t pick_op(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < (grow ? 35 : 10)) return OP_INS_V;
    if (r < 55) return OP_INS_E;
    if (r < (grow ? 60 : 75)) return OP_DEL_V;
    if (r < 80) return OP_DEL_E;
    if (r < 86) return OP_HAS_V;
    if (r < 93) return OP_HAS_E;
    if (r < 98) return OP_LOCATE;
    return OP_NOP;
  endfunction

  // load the next request on the input ports and predict its result
  task automatic load_next();
    op_t op;
    logic [7:0] a, b;
    logic [15:0] w;
    graph_result_t p;
    if (item_idx < dir_tab.size()) begin
      op = dir_tab[item_idx].op; a = dir_tab[item_idx].a;
      b = dir_tab[item_idx].b;   w = dir_tab[item_idx].w;
      p = graph_apply(op, a, b, w);
      next_res = dir_tab[item_idx].typed ? dir_tab[item_idx].res : p;
    end else begin
      // alternate growing and shrinking phases so the store fills up
      op = pick_op(((item_idx / 120) % 2) == 0);
      a = pick_label();
      b = pick_label();
      case ($urandom_range(0, 7))
        0: w = NONE_W;
        1: w = '0;
        default: w = 16'($urandom_range(0, 65535));
      endcase
      next_res = graph_apply(op, a, b, w);
    end
    in_op       <= op;
    in_vertex_a <= a;
    in_vertex_b <= b;
    in_weight   <= w;
    item_idx++;
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    logic go;
    if (rst_done) begin
      go = start;
      if (start && !busy) begin
        pending_results.push_back(next_res);
        go = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (!go) begin
        if (gap_left > 0) gap_left--;
        else if (item_idx < n_items) begin
          load_next();
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  // ---- checking ----
  task automatic report_mismatch(string what, int got, int exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    err_count++;
  endtask

  always @(posedge clk) begin
    graph_result_t e;
    if (rst_done) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $display("[%0t] result beat with nothing pending", $realtime);
          err_count++;
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
          if (out_answer !== e.answer) report_mismatch("answer", out_answer, e.answer);
          if (out_vertex_index !== e.index)
            report_mismatch("vertex_index", out_vertex_index, e.index);
          if (out_vertex_total !== e.total)
            report_mismatch("vertex_total", out_vertex_total, e.total);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    err_count = 0; idle_cycles = 0; item_idx = 0; g_count = 0;
    burst_left = 4; gap_left = 0; rst_done = 0;

    // empty store
    add_row(OP_HAS_V, 8'd5, 8'd0, 16'd0, 1, ST_OK, 0, 0, 0);
    add_row(OP_LOCATE, 8'd5, 8'd0, 16'd0, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_DEL_V, 8'd5, 8'd0, 16'd0, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_DEL_E, 8'd1, 8'd2, 16'd0, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_INS_E, 8'd1, 8'd2, 16'd7, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(OP_HAS_E, 8'd1, 8'd2, 16'd0, 1, ST_OK, 0, 0, 0);
    add_row(OP_NOP, 8'hFF, 8'hFF, 16'hFFFF, 1, ST_OK, 0, 0, 0);
    // extreme labels, duplicate
    add_row(OP_INS_V, 8'd0, 8'd0, 16'd0, 1, ST_OK, 0, 0, 1);
    add_row(OP_INS_V, 8'd255, 8'd0, 16'd0, 1, ST_OK, 0, 1, 2);
    add_row(OP_INS_V, 8'd0, 8'd0, 16'd0, 1, ST_DUP, 0, 0, 2);
    // edges: zero weight, self loop, missing edge, no-edge weight as delete
    add_row(OP_INS_E, 8'd0, 8'd255, 16'd0);
    add_row(OP_HAS_E, 8'd255, 8'd0, 16'd0);
    add_row(OP_INS_E, 8'd255, 8'd255, 16'hFFFE);
    add_row(OP_HAS_E, 8'd255, 8'd255, 16'd0);
    add_row(OP_DEL_E, 8'd0, 8'd255, 16'd0);
    add_row(OP_DEL_E, 8'd0, 8'd255, 16'd0, 1, ST_NO_EDGE, 0, 0, 2);
    add_row(OP_INS_E, 8'd0, 8'd255, 16'h1234);
    add_row(OP_INS_E, 8'd255, 8'd0, 16'hFFFF);
    add_row(OP_HAS_E, 8'd0, 8'd255, 16'd0);
    add_row(OP_LOCATE, 8'd255, 8'd0, 16'd0);
    add_row(OP_DEL_V, 8'd0, 8'd0, 16'd0);
    add_row(OP_LOCATE, 8'd255, 8'd0, 16'd0);
    n_items = dir_tab.size() + N_RANDOM;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rst_done = 1;

    wait (item_idx == n_items && !start && pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/amgs_pkg.sv
src/amgs_dp.sv
src/amgs_ctrl.sv
src/adjacency_matrix_graph_store_top.sv
tb/sv/testbench.sv
